// File: hw/rtl/kdeg_pkg.sv
`default_nettype none

package kdeg_pkg;

    typedef enum logic [2:0] {
        EV_PRESSED = 3'd0,
        EV_REPEAT  = 3'd1,
        EV_FAST    = 3'd2,
        EV_LONG    = 3'd3,
        EV_TIMEOUT = 3'd4
    } t_event_kind;

    localparam logic [2:0] CFG_LONGPRESS_MASK = 3'd0;
    localparam logic [2:0] CFG_REPEAT_MASK    = 3'd1;
    localparam logic [2:0] CFG_SETTLE_TIME    = 3'd2;
    localparam logic [2:0] CFG_REPEAT_START   = 3'd3;
    localparam logic [2:0] CFG_REPEAT_GAP_MAX = 3'd4;
    localparam logic [2:0] CFG_REPEAT_GAP_MIN = 3'd5;
    localparam logic [2:0] CFG_HOLD_LIMIT     = 3'd6;
    localparam logic [2:0] CFG_TIMEOUT_LIMIT  = 3'd7;

    localparam logic [7:0] RST_SETTLE_TIME    = 8'd12;
    localparam logic [7:0] RST_REPEAT_START   = 8'd200;
    localparam logic [7:0] RST_REPEAT_GAP_MAX = 8'd100;
    localparam logic [7:0] RST_REPEAT_GAP_MIN = 8'd20;
    localparam logic [7:0] RST_HOLD_LIMIT     = 8'd3;
    localparam logic [7:0] RST_TIMEOUT_LIMIT  = 8'd30;

    localparam logic [7:0] REPEAT_STEP = 8'd3;
    localparam logic [7:0] FAST_OFFSET = 8'd32;

    typedef struct packed {
        logic [7:0] longpress_mask;
        logic [7:0] repeat_mask;
        logic [7:0] settle_time;
        logic [7:0] repeat_start;
        logic [7:0] repeat_gap_max;
        logic [7:0] repeat_gap_min;
        logic [7:0] hold_limit;
        logic [7:0] timeout_limit;
    } t_kdeg_cfg;

    typedef struct packed {
        logic [7:0] tick_count;
        logic [7:0] sampled_keys;
        logic [7:0] stable_keys;
        logic [7:0] bounce_left;
        logic [7:0] repeat_left;
        logic [7:0] repeat_interval;
        logic [7:0] hold_periods;
        logic [7:0] idle_periods;
    } t_kdeg_state;

endpackage

`default_nettype wire

// File: hw/rtl/kdeg_step.sv
`default_nettype none

// One tick of debounce / repeat / long-press / timeout processing.
module kdeg_step #(
    parameter int NUM_KEYS = 8
) (
    input  wire kdeg_pkg::t_kdeg_cfg   i_cfg,
    input  wire kdeg_pkg::t_kdeg_state i_state,
    input  wire logic [7:0]            i_sample,
    output kdeg_pkg::t_kdeg_state      o_next,
    output logic                       o_have,
    output kdeg_pkg::t_event_kind      o_kind,
    output logic [7:0]                 o_keys
);

    localparam logic [7:0] KeyBits = 8'((1 << NUM_KEYS) - 1);

    logic [7:0] lp;
    logic [7:0] rp;
    logic [7:0] sample;
    logic [7:0] keys;
    logic [7:0] samp;
    logic [7:0] bl;
    logic [7:0] rl;
    logic [7:0] ri;
    logic [7:0] hold;
    logic [7:0] idle;
    logic       have;
    logic       lp_fire;
    kdeg_pkg::t_event_kind kind;

    always_comb begin
        lp      = i_cfg.longpress_mask & KeyBits;
        rp      = i_cfg.repeat_mask & KeyBits;
        sample  = i_sample & KeyBits;
        samp    = i_state.sampled_keys;
        bl      = i_state.bounce_left;
        keys    = i_state.stable_keys;
        rl      = i_state.repeat_left - 8'd1;
        ri      = i_state.repeat_interval;
        hold    = i_state.hold_periods;
        idle    = i_state.idle_periods;
        have    = 1'b0;
        lp_fire = 1'b0;
        kind    = kdeg_pkg::EV_PRESSED;

        if (sample != samp) begin
            samp = sample;
            bl   = i_cfg.settle_time;
        end

        if (rl == 8'd0 && (keys & rp) != 8'd0) begin
            have = 1'b1;
            kind = kdeg_pkg::EV_REPEAT;
            rl   = i_state.repeat_interval;
            if (i_state.repeat_interval > i_cfg.repeat_gap_min) begin
                ri = i_state.repeat_interval - kdeg_pkg::REPEAT_STEP;
            end else begin
                ri   = i_cfg.repeat_gap_max - kdeg_pkg::FAST_OFFSET;
                kind = kdeg_pkg::EV_FAST;
            end
        end

        if (bl != 8'd0) begin
            bl = bl - 8'd1;
        end else if (keys != samp) begin
            if (samp > keys) begin
                have = 1'b1;
                kind = kdeg_pkg::EV_PRESSED;
            end
            hold = 8'd0;
            rl   = i_cfg.repeat_start;
            ri   = i_cfg.repeat_gap_max;
            keys = samp;
        end

        if (have) begin
            idle = 8'd0;
        end

        // period boundary: every 256 ticks
        if (i_state.tick_count == 8'd0) begin
            if ((keys & lp) != 8'd0) begin
                hold    = hold + 8'd1;
                lp_fire = hold > i_cfg.hold_limit;
            end
            if (lp_fire) begin
                hold = 8'd0;
                have = 1'b1;
                kind = kdeg_pkg::EV_LONG;
                idle = 8'd0;
            end else begin
                idle = idle + 8'd1;
                if (idle > i_cfg.timeout_limit) begin
                    idle = 8'd0;
                    have = 1'b1;
                    kind = kdeg_pkg::EV_TIMEOUT;
                end
            end
        end

        o_next                 = i_state;
        o_next.tick_count      = i_state.tick_count + 8'd1;
        o_have                 = 1'b0;
        o_kind                 = kind;
        o_keys                 = keys;
        // odd ticks only advance the tick counter
        if (!i_state.tick_count[0]) begin
            o_next.sampled_keys    = samp;
            o_next.stable_keys     = keys;
            o_next.bounce_left     = bl;
            o_next.repeat_left     = rl;
            o_next.repeat_interval = ri;
            o_next.hold_periods    = hold;
            o_next.idle_periods    = idle;
            o_have                 = have;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/keypad_debounce_event_gen.sv
`default_nettype none

// Channel  Dir  Handshake                          Payload
// s_axis   in   i_s_axis_tvalid/o_s_axis_tready    tdata[7:0] key_sample
// m_axis   out  o_m_axis_tvalid/i_m_axis_tready    tdata[7:0] key_state,
//                                                  tuser[2:0] event_kind
// cfg      in   i_cfg_we (no wait)                 i_cfg_addr index, i_cfg_wdata
//
// One tick per clock while o_s_axis_tready is high: the step logic sits between the state
// registers and the result register, so each result is registered before it is offered.
// A two-entry output stage (result register plus skid) keeps input flowing while a
// result waits; input stalls only when both entries are full.
// Synchronous active-low reset sets config registers to their defaults and
// clears the state; no clearing pass is needed.
module keypad_debounce_event_gen #(
    parameter int NUM_KEYS = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] key_sample
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // [7:0] key_state
    output logic [2:0]      o_m_axis_tuser,   // [2:0] event_kind
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_addr,
    input  wire logic [7:0] i_cfg_wdata
);

    kdeg_pkg::t_kdeg_cfg   r_cfg;
    kdeg_pkg::t_kdeg_state r_state;
    kdeg_pkg::t_kdeg_state n_state;

    logic                  step_have;
    kdeg_pkg::t_event_kind step_kind;
    logic [7:0]            step_keys;

    logic                  r_out_valid;
    kdeg_pkg::t_event_kind r_out_kind;
    logic [7:0]            r_out_keys;
    logic                  r_skid_valid;
    kdeg_pkg::t_event_kind r_skid_kind;
    logic [7:0]            r_skid_keys;

    logic accept;
    logic pop;
    logic push;

    kdeg_step #(
        .NUM_KEYS (NUM_KEYS)
    ) u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_sample (i_s_axis_tdata),
        .o_next   (n_state),
        .o_have   (step_have),
        .o_kind   (step_kind),
        .o_keys   (step_keys)
    );

    assign o_s_axis_tready = !r_skid_valid;
    assign accept          = i_s_axis_tvalid && !r_skid_valid;
    assign pop             = r_out_valid && i_m_axis_tready;
    assign push            = accept && step_have;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_keys;
    assign o_m_axis_tuser  = r_out_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.longpress_mask <= 8'd0;
            r_cfg.repeat_mask    <= 8'd0;
            r_cfg.settle_time    <= kdeg_pkg::RST_SETTLE_TIME;
            r_cfg.repeat_start   <= kdeg_pkg::RST_REPEAT_START;
            r_cfg.repeat_gap_max <= kdeg_pkg::RST_REPEAT_GAP_MAX;
            r_cfg.repeat_gap_min <= kdeg_pkg::RST_REPEAT_GAP_MIN;
            r_cfg.hold_limit     <= kdeg_pkg::RST_HOLD_LIMIT;
            r_cfg.timeout_limit  <= kdeg_pkg::RST_TIMEOUT_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                kdeg_pkg::CFG_LONGPRESS_MASK: r_cfg.longpress_mask <= i_cfg_wdata;
                kdeg_pkg::CFG_REPEAT_MASK:    r_cfg.repeat_mask    <= i_cfg_wdata;
                kdeg_pkg::CFG_SETTLE_TIME:    r_cfg.settle_time    <= i_cfg_wdata;
                kdeg_pkg::CFG_REPEAT_START:   r_cfg.repeat_start   <= i_cfg_wdata;
                kdeg_pkg::CFG_REPEAT_GAP_MAX: r_cfg.repeat_gap_max <= i_cfg_wdata;
                kdeg_pkg::CFG_REPEAT_GAP_MIN: r_cfg.repeat_gap_min <= i_cfg_wdata;
                kdeg_pkg::CFG_HOLD_LIMIT:     r_cfg.hold_limit     <= i_cfg_wdata;
                kdeg_pkg::CFG_TIMEOUT_LIMIT:  r_cfg.timeout_limit  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // result register plus skid entry; skid is only loaded when the result
    // register is full and not draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out_kind <= r_skid_kind;
                r_out_keys <= r_skid_keys;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out_kind <= step_kind;
                r_out_keys <= step_keys;
            end else begin
                r_skid_kind <= step_kind;
                r_skid_keys <= step_keys;
            end
        end
    end

endmodule

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         NUM_KEYS    = 8;
    localparam logic [7:0] KEY_MASK    = 8'((1 << NUM_KEYS) - 1);
    localparam int         HOLD_CYCLES = 400;
    localparam int         SETTLE_CYC  = 4;

    typedef struct packed {
        kdeg_pkg::t_event_kind kind;
        logic [7:0]            keys;
    } t_key_event;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       s_valid   = 1'b0;
    logic [7:0] s_data    = 8'h00;
    logic       m_ready   = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [2:0] cfg_addr  = kdeg_pkg::CFG_LONGPRESS_MASK;
    logic [7:0] cfg_wdata = 8'h00;

    wire logic       s_ready;
    wire logic       m_valid;
    wire logic [7:0] m_data;
    wire logic [2:0] m_user;

    keypad_debounce_event_gen #(
        .NUM_KEYS(NUM_KEYS)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    always #10 clk = ~clk;

    // stimulus and expectation stores
    logic [7:0]  key_q[$];
    t_key_event  event_q[$];
    int          error_count   = 0;
    int unsigned src_idle_pct  = 0;
    int unsigned snk_stall_pct = 0;
    int          hold_trigger  = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;
    logic        key_taken     = 1'b0;

    // predictor copy of registers and state
    kdeg_pkg::t_kdeg_cfg cfg;
    logic [7:0] tick_ctr, raw_keys, debounced, settle_left;
    logic [7:0] rpt_left, rpt_gap, hold_cnt, idle_cnt;

    initial begin
        cfg.longpress_mask = 8'h00;
        cfg.repeat_mask    = 8'h00;
        cfg.settle_time    = kdeg_pkg::RST_SETTLE_TIME;
        cfg.repeat_start   = kdeg_pkg::RST_REPEAT_START;
        cfg.repeat_gap_max = kdeg_pkg::RST_REPEAT_GAP_MAX;
        cfg.repeat_gap_min = kdeg_pkg::RST_REPEAT_GAP_MIN;
        cfg.hold_limit     = kdeg_pkg::RST_HOLD_LIMIT;
        cfg.timeout_limit  = kdeg_pkg::RST_TIMEOUT_LIMIT;
        tick_ctr    = 8'h00;
        raw_keys    = 8'h00;
        debounced   = 8'h00;
        settle_left = 8'h00;
        rpt_left    = 8'h00;
        rpt_gap     = 8'h00;
        hold_cnt    = 8'h00;
        idle_cnt    = 8'h00;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    // one tick through the debounce / event predictor
    task automatic predict_tick(input logic [7:0] sample_in, output bit fire,
                                output kdeg_pkg::t_event_kind kind,
                                output logic [7:0] keys);
        logic [7:0] smp;
        logic [7:0] lpk;
        logic [7:0] rpk;
        bit         lp_fire;
        fire = 1'b0;
        kind = kdeg_pkg::EV_PRESSED;
        keys = debounced;
        if (tick_ctr[0]) begin
            tick_ctr = tick_ctr + 8'd1;
            return;
        end
        smp = sample_in & KEY_MASK;
        lpk = cfg.longpress_mask & KEY_MASK;
        rpk = cfg.repeat_mask & KEY_MASK;
        if (smp != raw_keys) begin
            raw_keys    = smp;
            settle_left = cfg.settle_time;
        end
        rpt_left = rpt_left - 8'd1;
        if (rpt_left == 8'd0 && (keys & rpk) != 8'd0) begin
            fire     = 1'b1;
            kind     = kdeg_pkg::EV_REPEAT;
            rpt_left = rpt_gap;
            if (rpt_gap > cfg.repeat_gap_min) begin
                rpt_gap = rpt_gap - kdeg_pkg::REPEAT_STEP;
            end else begin
                rpt_gap = cfg.repeat_gap_max - kdeg_pkg::FAST_OFFSET;
                kind    = kdeg_pkg::EV_FAST;
            end
        end
        if (settle_left != 8'd0) begin
            settle_left = settle_left - 8'd1;
        end else if (keys != raw_keys) begin
            if (raw_keys > keys) begin
                fire = 1'b1;
                kind = kdeg_pkg::EV_PRESSED;
            end
            hold_cnt = 8'd0;
            rpt_left = cfg.repeat_start;
            rpt_gap  = cfg.repeat_gap_max;
            keys     = raw_keys;
        end
        if (fire) idle_cnt = 8'd0;
        // 256-tick boundary: long press or idle timeout
        if (tick_ctr == 8'd0) begin
            lp_fire = 1'b0;
            if ((keys & lpk) != 8'd0) begin
                hold_cnt = hold_cnt + 8'd1;
                lp_fire  = hold_cnt > cfg.hold_limit;
            end
            if (lp_fire) begin
                hold_cnt = 8'd0;
                fire     = 1'b1;
                kind     = kdeg_pkg::EV_LONG;
                idle_cnt = 8'd0;
            end else begin
                idle_cnt = idle_cnt + 8'd1;
                if (idle_cnt > cfg.timeout_limit) begin
                    idle_cnt = 8'd0;
                    fire     = 1'b1;
                    kind     = kdeg_pkg::EV_TIMEOUT;
                end
            end
        end
        debounced = keys;
        tick_ctr  = tick_ctr + 8'd1;
    endtask

    // key sample driver
    always @(negedge clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || key_taken) begin
            if (key_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= key_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // event receiver, with a long hold-off on request
    always @(negedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_trigger != hold_served) begin
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_trigger;
            m_ready     <= 1'b0;
        end else begin
            m_ready <= rst_n && ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // transfer monitor: predict on input, check on output
    always @(posedge clk) begin
        bit                    got;
        kdeg_pkg::t_event_kind kind;
        logic [7:0]            keys;
        t_key_event            exp_ev;
        key_taken <= rst_n && s_valid && s_ready;
        if (rst_n && s_valid && s_ready) begin
            predict_tick(s_data, got, kind, keys);
            if (got) event_q.push_back('{kind: kind, keys: keys});
        end
        if (rst_n && m_valid && m_ready) begin
            if (event_q.size() == 0) begin
                report_mismatch($sformatf("unexpected event kind %0d keys %02h",
                                          m_user, m_data));
            end else begin
                exp_ev = event_q.pop_front();
                if (m_user !== exp_ev.kind)
                    report_mismatch($sformatf("event kind %0d, want %0d",
                                              m_user, exp_ev.kind));
                if (m_data !== exp_ev.keys)
                    report_mismatch($sformatf("key state %02h, want %02h",
                                              m_data, exp_ev.keys));
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            kdeg_pkg::CFG_LONGPRESS_MASK: cfg.longpress_mask = val;
            kdeg_pkg::CFG_REPEAT_MASK:    cfg.repeat_mask    = val;
            kdeg_pkg::CFG_SETTLE_TIME:    cfg.settle_time    = val;
            kdeg_pkg::CFG_REPEAT_START:   cfg.repeat_start   = val;
            kdeg_pkg::CFG_REPEAT_GAP_MAX: cfg.repeat_gap_max = val;
            kdeg_pkg::CFG_REPEAT_GAP_MIN: cfg.repeat_gap_min = val;
            kdeg_pkg::CFG_HOLD_LIMIT:     cfg.hold_limit     = val;
            kdeg_pkg::CFG_TIMEOUT_LIMIT:  cfg.timeout_limit  = val;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [7:0] lp, input logic [7:0] rp,
                             input logic [7:0] bt, input logic [7:0] dbr,
                             input logic [7:0] maxd, input logic [7:0] mind,
                             input logic [7:0] lpd, input logic [7:0] tmo);
        write_reg(kdeg_pkg::CFG_LONGPRESS_MASK, lp);
        write_reg(kdeg_pkg::CFG_REPEAT_MASK, rp);
        write_reg(kdeg_pkg::CFG_SETTLE_TIME, bt);
        write_reg(kdeg_pkg::CFG_REPEAT_START, dbr);
        write_reg(kdeg_pkg::CFG_REPEAT_GAP_MAX, maxd);
        write_reg(kdeg_pkg::CFG_REPEAT_GAP_MIN, mind);
        write_reg(kdeg_pkg::CFG_HOLD_LIMIT, lpd);
        write_reg(kdeg_pkg::CFG_TIMEOUT_LIMIT, tmo);
    endtask

    task automatic wait_drained();
        while (key_q.size() != 0 || s_valid || event_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // mostly debounced holds, some with chatter up front, some raw noise
    task automatic queue_key_runs(input int n_items);
        int         pushed;
        int         len;
        int         pick;
        logic [7:0] mask;
        pushed = 0;
        while (pushed < n_items) begin
            if ($urandom_range(0, 99) < 15) begin
                len = $urandom_range(1, 12);
                if (len > n_items - pushed) len = n_items - pushed;
                repeat (len) key_q.push_back(8'($urandom));
                pushed += len;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 25)      mask = 8'h00;
                else if (pick < 40) mask = 8'hFF;
                else                mask = 8'($urandom);
                if ($urandom_range(0, 1)) begin
                    len = $urandom_range(1, 6);
                    if (len > n_items - pushed) len = n_items - pushed;
                    repeat (len) key_q.push_back(mask ^ (8'd1 << $urandom_range(0, 7)));
                    pushed += len;
                end
                len = 2 * (int'(cfg.settle_time) + 1);
                if ($urandom_range(0, 9) == 0) len += $urandom_range(200, 500);
                else                           len += $urandom_range(0, 40);
                if (len > n_items - pushed) len = n_items - pushed;
                repeat (len) key_q.push_back(mask);
                pushed += len;
            end
        end
    endtask

    task automatic run_phase(input logic [7:0] lp, input logic [7:0] rp,
                             input logic [7:0] bt, input logic [7:0] dbr,
                             input logic [7:0] maxd, input logic [7:0] mind,
                             input logic [7:0] lpd, input logic [7:0] tmo,
                             input int unsigned src_pct, input int unsigned snk_pct,
                             input int n_items, input bit hold_off);
        write_all(lp, rp, bt, dbr, maxd, mind, lpd, tmo);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        if (hold_off) hold_trigger++;
        queue_key_runs(n_items);
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: reset defaults with instant debounce, field extremes
        write_reg(kdeg_pkg::CFG_SETTLE_TIME, 8'd0);
        key_q.push_back(8'h00); key_q.push_back(8'hFF); key_q.push_back(8'hFF);
        key_q.push_back(8'h00); key_q.push_back(8'h00); key_q.push_back(8'h01);
        key_q.push_back(8'h01); key_q.push_back(8'h80); key_q.push_back(8'h80);
        key_q.push_back(8'hFE); key_q.push_back(8'hFE); key_q.push_back(8'h7F);
        wait_drained();

        // directed: repeat every step, so repeat and pressed land on one tick
        write_all(8'h01, 8'hFF, 8'd0, 8'd1, 8'd33, 8'd255, 8'd0, 8'd0);
        key_q.push_back(8'hAA); key_q.push_back(8'hAA); key_q.push_back(8'h55);
        key_q.push_back(8'h55); key_q.push_back(8'hFF); key_q.push_back(8'hFF);
        key_q.push_back(8'hFF); key_q.push_back(8'hFF); key_q.push_back(8'hFF);
        key_q.push_back(8'hFF); key_q.push_back(8'h00); key_q.push_back(8'h00);
        key_q.push_back(8'h01);
        wait_drained();

        // random phases across settings and idle patterns
        run_phase(8'h0F, 8'hF0, 8'd2, 8'd4, 8'd60, 8'd20, 8'd0, 8'd0,
                  56, 0, 200, 1'b0);
        // fast repeat on every processed tick fills the output while held off
        run_phase(8'hFF, 8'hFF, 8'd0, 8'd1, 8'd33, 8'd255, 8'd1, 8'd1,
                  0, 0, 250, 1'b1);
        // interval walks down past zero and wraps
        run_phase(8'h00, 8'h81, 8'd1, 8'd2, 8'd34, 8'd0, 8'd255, 8'd255,
                  0, 56, 350, 1'b0);
        run_phase(8'hAA, 8'h55, 8'd255, 8'd255, 8'd255, 8'd254, 8'd0, 8'd0,
                  6, 6, 700, 1'b0);
        run_phase(8'h00, 8'h00, kdeg_pkg::RST_SETTLE_TIME, kdeg_pkg::RST_REPEAT_START,
                  kdeg_pkg::RST_REPEAT_GAP_MAX, kdeg_pkg::RST_REPEAT_GAP_MIN,
                  kdeg_pkg::RST_HOLD_LIMIT, kdeg_pkg::RST_TIMEOUT_LIMIT,
                  0, 0, 200, 1'b0);

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/kdeg_pkg.sv
hw/rtl/kdeg_step.sv
hw/rtl/keypad_debounce_event_gen.sv
tb/testbench.sv
